// File: hdl/gain_sequence_frame_packer_core_macros.svh
// Assertion helpers for the packer RTL, included by gsfp_seq.
// GSFP_ASSERT:      property checked at every clock edge out of reset.
// GSFP_ASSERT_NEXT: antecedent this cycle implies consequent next cycle.
`ifndef GAIN_SEQUENCE_FRAME_PACKER_CORE_MACROS_SVH
`define GAIN_SEQUENCE_FRAME_PACKER_CORE_MACROS_SVH

`define GSFP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define GSFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/gsfp_pkg.sv
// ----------------------------------------------------------------------------
// gsfp_pkg
// Types, codes and default constants of the gain sequence frame packer.
// ----------------------------------------------------------------------------
`default_nettype none

package gsfp_pkg;

    localparam int K_NUM_TRANSDUCERS     = 249;
    localparam int K_SEGMENT_FRAMES_LOG2 = 5;
    localparam int K_FRAME_STRIDE_LOG2   = 9;

    localparam int ADDR_W  = 14;
    localparam int VALUE_W = 16;
    localparam int DATA_W  = 32;
    localparam int STEP_W  = 3;

    localparam logic [7:0]  HI_FILL     = 8'hFF;
    localparam logic [15:0] DMODE_PFULL = 16'h0002;
    localparam logic [15:0] DMODE_PHALF = 16'h0004;

    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_GAIN  = 2'd1,
        OP_CYCLE = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        GM_FULL  = 2'd0,
        GM_PFULL = 2'd1,
        GM_PHALF = 2'd2
    } t_gmode;

    typedef enum logic [1:0] {
        KIND_MEM  = 2'd0,
        KIND_PAGE = 2'd1,
        KIND_FDIV = 2'd2,
        KIND_END  = 2'd3
    } t_kind;

    typedef struct packed {
        t_op                  op;
        logic [7:0]           index;
        logic [VALUE_W-1:0]   value;
        logic [DATA_W-1:0]    divider;
        t_gmode               mode;
        logic                 is_duty;
        logic                 last;
        logic                 seq_end;
        logic                 ok;
    } t_item;

    typedef struct packed {
        t_kind                kind;
        logic [ADDR_W-1:0]    address;
        logic [DATA_W-1:0]    data;
        logic                 last_of_run;
    } t_result;

    typedef struct packed {
        logic busy;
        logic retire;
        logic emit;
    } t_seq_status;

endpackage

`default_nettype wire

// File: hdl/gsfp_ram.sv
// ----------------------------------------------------------------------------
// gsfp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gsfp_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        // hold the last read word until the next read
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/gsfp_seq.sv
// ----------------------------------------------------------------------------
// gsfp_seq
// Work stage: holds one item, owns frame count and gain mode, and emits its
// result words one per cycle while i_emit_ok is high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "gain_sequence_frame_packer_core_macros.svh"

module gsfp_seq #(
    parameter int SEGMENT_FRAMES_LOG2 = gsfp_pkg::K_SEGMENT_FRAMES_LOG2,
    parameter int FRAME_STRIDE_LOG2   = gsfp_pkg::K_FRAME_STRIDE_LOG2
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_load,
    input  wire gsfp_pkg::t_item                 i_item,
    input  wire logic [gsfp_pkg::VALUE_W-1:0]    i_cycle,
    input  wire logic                            i_legacy,
    input  wire logic                            i_emit_ok,
    output gsfp_pkg::t_seq_status                o_status,
    output gsfp_pkg::t_result                    o_result
);
    import gsfp_pkg::*;

    localparam int SEG   = SEGMENT_FRAMES_LOG2;
    localparam int FS    = FRAME_STRIDE_LOG2;
    localparam int SUM_W = ((SEG + FS) > 9 ? (SEG + FS) : 9) + 1;

    logic              r_valid, n_valid;
    t_item             r_item;
    logic [STEP_W-1:0] r_step, n_step;
    logic [DATA_W-1:0] r_count, n_count;
    t_gmode            r_mode, n_mode;

    logic [STEP_W-1:0] w_nm, w_adv, w_eff_adv, w_n;
    logic              w_fk, w_oddk, w_oddf, w_pg, w_en;
    logic [DATA_W-1:0] w_sum, w_sum_m1;
    logic              w_emit, w_retire;
    t_result           w_res;

    logic [SEG-1:0]    w_slot;
    logic              w_odd;
    logic [SUM_W-1:0]  w_addr_sum;
    logic [3:0]        w_nib;

    // per-item plan: memory writes and frame advance
    always_comb begin
        w_nm   = '0;
        w_adv  = '0;
        w_fk   = 1'b0;
        w_oddk = 1'b0;
        w_oddf = 1'b0;
        if (r_item.op == OP_GAIN) begin
            case (r_mode)
                GM_PFULL: begin
                    if (i_legacy) begin
                        w_nm  = r_item.ok ? 3'd2 : 3'd0;
                        w_adv = 3'd2;
                        w_fk  = 1'b1;
                    end else if (!r_item.is_duty) begin
                        w_nm   = r_item.ok ? 3'd2 : 3'd0;
                        w_adv  = 3'd1;
                        w_oddk = 1'b1;
                    end
                end
                GM_PHALF: begin
                    if (i_legacy) begin
                        w_nm  = r_item.ok ? 3'd4 : 3'd0;
                        w_adv = 3'd4;
                        w_fk  = 1'b1;
                    end
                end
                default: begin
                    w_nm   = r_item.ok ? 3'd1 : 3'd0;
                    w_adv  = (i_legacy || r_item.is_duty) ? 3'd1 : 3'd0;
                    w_oddf = !i_legacy && r_item.is_duty;
                end
            endcase
        end
        w_eff_adv = r_item.last ? w_adv : 3'd0;
    end

    assign w_sum    = r_count + DATA_W'(w_eff_adv);
    assign w_sum_m1 = r_count + DATA_W'(w_eff_adv) - DATA_W'(1);

    assign w_pg = r_item.last && (w_sum[SEG-1:0] == '0);
    assign w_en = r_item.last && r_item.seq_end;

    always_comb begin
        case (r_item.op)
            OP_BEGIN: w_n = 3'd2;
            OP_GAIN:  w_n = w_nm + {2'b0, w_pg} + {2'b0, w_en};
            default:  w_n = 3'd0;
        endcase
    end

    // memory write address and data for step r_step
    assign w_slot     = r_count[SEG-1:0] + (w_fk ? SEG'(r_step) : SEG'(0));
    assign w_odd      = w_oddk ? r_step[0] : w_oddf;
    assign w_addr_sum = (SUM_W'(w_slot) << FS) + SUM_W'({r_item.index, w_odd});
    assign w_nib      = r_item.value[{r_step[1:0], 2'b00} +: 4];

    always_comb begin
        w_res.kind        = KIND_MEM;
        w_res.address     = '0;
        w_res.data        = '0;
        w_res.last_of_run = (r_step == w_n - 3'd1);
        if (r_item.op == OP_BEGIN) begin
            if (r_step == 3'd0) begin
                w_res.kind = KIND_PAGE;
            end else begin
                w_res.kind = KIND_FDIV;
                w_res.data = r_item.divider;
            end
        end else if (r_step < w_nm) begin
            w_res.address = w_addr_sum[ADDR_W-1:0];
            case (r_mode)
                GM_PFULL: begin
                    if (i_legacy) begin
                        w_res.data = DATA_W'({HI_FILL,
                            r_step[0] ? r_item.value[15:8] : r_item.value[7:0]});
                    end else if (r_step[0]) begin
                        w_res.data = DATA_W'(i_cycle[VALUE_W-1:1]);
                    end else begin
                        w_res.data = DATA_W'(r_item.value);
                    end
                end
                GM_PHALF: w_res.data = DATA_W'({HI_FILL, w_nib, w_nib});
                default:  w_res.data = DATA_W'(r_item.value);
            endcase
        end else if (r_step == w_nm && w_pg) begin
            w_res.kind = KIND_PAGE;
            w_res.data = w_sum >> SEG;
        end else begin
            w_res.kind = KIND_END;
            w_res.data = (w_sum == '0) ? '0 : w_sum_m1;
        end
    end

    assign w_emit   = r_valid && (w_n != 3'd0) && i_emit_ok;
    assign w_retire = r_valid && ((w_n == 3'd0) || (w_emit && w_res.last_of_run));

    always_comb begin
        n_valid = r_valid;
        n_step  = r_step;
        n_count = r_count;
        n_mode  = r_mode;
        if (w_retire) begin
            n_valid = 1'b0;
            n_step  = '0;
            if (r_item.op == OP_BEGIN) begin
                n_count = '0;
                n_mode  = r_item.mode;
            end else if (r_item.op == OP_GAIN && r_item.last) begin
                n_count = w_sum;
            end
        end else if (w_emit) begin
            n_step = r_step + 3'd1;
        end
        if (i_load) begin
            n_valid = 1'b1;
            n_step  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
            r_count <= '0;
            r_mode  <= GM_FULL;
        end else begin
            r_valid <= n_valid;
            r_step  <= n_step;
            r_count <= n_count;
            r_mode  <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_status.busy   = r_valid;
    assign o_status.retire = w_retire;
    assign o_status.emit   = w_emit;
    assign o_result        = w_res;

    `GSFP_ASSERT(a_step_in_range, i_clk, i_rst_n,
        (r_valid && (w_n != 3'd0)) |-> (r_step < w_n), "step past result count")
    `GSFP_ASSERT(a_last_retires, i_clk, i_rst_n,
        (w_emit && w_res.last_of_run) |-> w_retire, "final word without retire")
    `GSFP_ASSERT_NEXT(a_begin_clears, i_clk, i_rst_n,
        w_retire && (r_item.op == OP_BEGIN), r_count == '0, "begin left count")
    `GSFP_ASSERT_NEXT(a_count_holds, i_clk, i_rst_n,
        w_retire && (r_item.op == OP_GAIN) && !r_item.last, $stable(r_count),
        "count moved without last")

endmodule

`default_nettype wire

// File: hdl/gain_sequence_frame_packer_core.sv
// An accepted item is registered in the work stage; its result words then pass the output register.
// Throughput: one result word per cycle while the output register can take it
// (up to 6 per item, four memory writes in phase-half legacy mode); a new item
// is accepted as the last one retires. The rate is set by the work stage feeding the output register.
// Reset: frame count 0, mode phase-duty full, legacy on; the cycle RAM is not cleared.
// ----------------------------------------------------------------------------
// gain_sequence_frame_packer_core
// Packs gain words into sequence-memory writes plus page, divider and end words.
// ----------------------------------------------------------------------------
`default_nettype none

module gain_sequence_frame_packer_core #(
    parameter int NUM_TRANSDUCERS     = gsfp_pkg::K_NUM_TRANSDUCERS,
    parameter int SEGMENT_FRAMES_LOG2 = gsfp_pkg::K_SEGMENT_FRAMES_LOG2,
    parameter int FRAME_STRIDE_LOG2   = gsfp_pkg::K_FRAME_STRIDE_LOG2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [7:0]  i_index,
    input  wire logic [15:0] i_value,
    input  wire logic [31:0] i_divider,
    input  wire logic [15:0] i_data_mode,
    input  wire logic        i_is_duty,
    input  wire logic        i_last,
    input  wire logic        i_seq_end,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_kind,
    output logic [13:0]      o_address,
    output logic [31:0]      o_data,
    output logic             o_last_of_run
);
    import gsfp_pkg::*;

    localparam int CYC_AW = (NUM_TRANSDUCERS > 1) ? $clog2(NUM_TRANSDUCERS) : 1;

    logic         r_legacy;
    logic         r_o_valid;
    t_result      r_o_res;
    logic         w_accept, w_emit_ok;
    t_item        w_item;
    t_seq_status  w_status;
    t_result      w_res;
    logic [VALUE_W-1:0] w_cycle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_legacy <= 1'b1;
        end else if (i_cfg_we) begin
            r_legacy <= i_cfg_wdata;
        end
    end

    always_comb begin
        w_item.op       = t_op'(i_op);
        w_item.index    = i_index;
        w_item.value    = i_value;
        w_item.divider  = i_divider;
        w_item.is_duty  = i_is_duty;
        w_item.last     = i_last;
        w_item.seq_end  = i_seq_end;
        w_item.ok       = ({1'b0, i_index} < 9'(NUM_TRANSDUCERS));
        if (i_data_mode == DMODE_PFULL) begin
            w_item.mode = GM_PFULL;
        end else if (i_data_mode == DMODE_PHALF) begin
            w_item.mode = GM_PHALF;
        end else begin
            w_item.mode = GM_FULL;
        end
    end

    assign w_emit_ok  = !r_o_valid || i_out_ready;
    assign o_in_ready = !w_status.busy || w_status.retire;
    assign w_accept   = i_in_valid && o_in_ready;

    // cycle loads write at accept; a gain word reads its entry at accept
    gsfp_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (NUM_TRANSDUCERS)
    ) u_cycle_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && (w_item.op == OP_CYCLE) && w_item.ok),
        .i_waddr (i_index[CYC_AW-1:0]),
        .i_wdata (i_value),
        .i_re    (w_accept && (w_item.op == OP_GAIN) && w_item.ok),
        .i_raddr (i_index[CYC_AW-1:0]),
        .o_rdata (w_cycle)
    );

    gsfp_seq #(
        .SEGMENT_FRAMES_LOG2 (SEGMENT_FRAMES_LOG2),
        .FRAME_STRIDE_LOG2   (FRAME_STRIDE_LOG2)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_accept),
        .i_item    (w_item),
        .i_cycle   (w_cycle),
        .i_legacy  (r_legacy),
        .i_emit_ok (w_emit_ok),
        .o_status  (w_status),
        .o_result  (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_status.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_status.emit) begin
            r_o_res <= w_res;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_kind        = r_o_res.kind;
    assign o_address     = r_o_res.address;
    assign o_data        = r_o_res.data;
    assign o_last_of_run = r_o_res.last_of_run;

endmodule

`default_nettype wire

// File: test/frame_write_checker.sv
// ----------------------------------------------------------------------------
// frame_write_checker
// Watches both channels of the frame packer, expands every accepted input word
// into the writes it should cause, and compares the output words in order.
// ----------------------------------------------------------------------------
module frame_write_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_index,
    input  logic [15:0] i_value,
    input  logic [31:0] i_divider,
    input  logic [15:0] i_data_mode,
    input  logic        i_is_duty,
    input  logic        i_last,
    input  logic        i_seq_end,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_kind,
    input  logic [13:0] i_address,
    input  logic [31:0] i_data,
    input  logic        i_last_of_run,
    output int          o_mismatches,
    output int          o_waiting
);
    import gsfp_pkg::*;

    localparam logic [31:0] SLOT_MASK = (32'd1 << K_SEGMENT_FRAMES_LOG2) - 32'd1;

    logic        legacy;
    logic [31:0] frames;
    t_gmode      mode;
    logic [15:0] cycle_mem [K_NUM_TRANSDUCERS];
    t_result     pending_writes [$];
    t_result     want;
    int          mismatches;

    task automatic report(input string msg);
        $display("frame writes: %s", msg);
        mismatches++;
    endtask

    function automatic logic [13:0] frame_addr(input logic [31:0] frame,
                                               input logic [7:0] idx, input logic odd);
        logic [31:0] a;
        a = ((frame & SLOT_MASK) << K_FRAME_STRIDE_LOG2) + 32'(idx) * 32'd2 + 32'(odd);
        return a[ADDR_W-1:0];
    endfunction

    function automatic t_result result_word(input t_kind kind, input logic [13:0] addr,
                                            input logic [31:0] data);
        return '{kind, addr, data, 1'b0};
    endfunction

    task automatic expand_word(input logic [1:0] op, input logic [7:0] idx,
                               input logic [15:0] val, input logic [31:0] fdiv,
                               input logic [15:0] dmode, input logic duty,
                               input logic last, input logic seq_end);
        t_result     burst [$];
        logic        ok;
        logic [31:0] adv;
        logic [3:0]  nib;
        ok = idx < K_NUM_TRANSDUCERS;
        adv = '0;
        case (op)
            OP_BEGIN: begin
                frames = '0;
                mode = (dmode == DMODE_PFULL) ? GM_PFULL :
                       (dmode == DMODE_PHALF) ? GM_PHALF : GM_FULL;
                burst.push_back(result_word(KIND_PAGE, '0, '0));
                burst.push_back(result_word(KIND_FDIV, '0, fdiv));
            end
            OP_CYCLE: begin
                if (ok) cycle_mem[idx] = val;
            end
            OP_GAIN: begin
                case (mode)
                    GM_PFULL: begin
                        if (legacy) begin
                            // low byte into this frame, high byte into the next
                            if (ok) begin
                                burst.push_back(result_word(KIND_MEM, frame_addr(frames, idx, 1'b0),
                                                            {16'h0, HI_FILL, val[7:0]}));
                                burst.push_back(result_word(KIND_MEM,
                                                            frame_addr(frames + 32'd1, idx, 1'b0),
                                                            {16'h0, HI_FILL, val[15:8]}));
                            end
                            adv = 32'd2;
                        end else if (!duty) begin
                            if (ok) begin
                                burst.push_back(result_word(KIND_MEM, frame_addr(frames, idx, 1'b0),
                                                            {16'h0, val}));
                                burst.push_back(result_word(KIND_MEM, frame_addr(frames, idx, 1'b1),
                                                            {17'h0, cycle_mem[idx][15:1]}));
                            end
                            adv = 32'd1;
                        end
                    end
                    GM_PHALF: begin
                        if (legacy) begin
                            for (int k = 0; k < 4; k++) begin
                                nib = val[4*k +: 4];
                                if (ok) begin
                                    burst.push_back(result_word(KIND_MEM,
                                                                frame_addr(frames + 32'(k), idx, 1'b0),
                                                                {16'h0, HI_FILL, nib, nib}));
                                end
                            end
                            adv = 32'd4;
                        end
                    end
                    default: begin
                        if (ok) begin
                            burst.push_back(result_word(KIND_MEM,
                                                        frame_addr(frames, idx, !legacy && duty),
                                                        {16'h0, val}));
                        end
                        adv = (legacy || duty) ? 32'd1 : 32'd0;
                    end
                endcase
                if (last) begin
                    frames += adv;
                    // page check runs even when nothing was added
                    if ((frames & SLOT_MASK) == '0) begin
                        burst.push_back(result_word(KIND_PAGE, '0,
                                                    frames >> K_SEGMENT_FRAMES_LOG2));
                    end
                    if (seq_end) begin
                        burst.push_back(result_word(KIND_END, '0,
                                                    (frames == '0) ? '0 : frames - 32'd1));
                    end
                end
            end
            default: ;
        endcase
        if (burst.size() > 0) burst[burst.size()-1].last_of_run = 1'b1;
        foreach (burst[i]) pending_writes.push_back(burst[i]);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            legacy = 1'b1;
            frames = '0;
            mode = GM_FULL;
            pending_writes.delete();
        end else begin
            if (i_cfg_we) legacy = i_cfg_wdata;
            if (i_out_valid && i_out_ready) begin
                if (pending_writes.size() == 0) begin
                    report($sformatf("unexpected word kind %0d addr %0h data %0h",
                                     i_kind, i_address, i_data));
                end else begin
                    want = pending_writes.pop_front();
                    if (i_kind !== want.kind)
                        report($sformatf("kind %0d, expected %0d", i_kind, want.kind));
                    if (i_address !== want.address)
                        report($sformatf("address %0h, expected %0h", i_address, want.address));
                    if (i_data !== want.data)
                        report($sformatf("data %0h, expected %0h", i_data, want.data));
                    if (i_last_of_run !== want.last_of_run)
                        report($sformatf("last_of_run %0b, expected %0b",
                                         i_last_of_run, want.last_of_run));
                end
            end
            if (i_in_valid && i_in_ready) begin
                expand_word(i_op, i_index, i_value, i_divider, i_data_mode,
                            i_is_duty, i_last, i_seq_end);
            end
        end
        o_waiting <= pending_writes.size();
        o_mismatches <= mismatches;
    end

endmodule

// File: test/gain_sequence_frame_packer_core_tb.sv
// ----------------------------------------------------------------------------
// gain_sequence_frame_packer_core_tb
// Drives begin, gain, cycle and unknown-op words through the packer in both frame formats,
// with random gaps on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module gain_sequence_frame_packer_core_tb;
    import gsfp_pkg::*;

    localparam int         STALL_LIMIT = 2000;
    localparam logic [1:0] OP_UNKNOWN  = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_op;
    logic [7:0]  i_index;
    logic [15:0] i_value;
    logic [31:0] i_divider;
    logic [15:0] i_data_mode;
    logic        i_is_duty;
    logic        i_last;
    logic        i_seq_end;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_kind;
    logic [13:0] o_address;
    logic [31:0] o_data;
    logic        o_last_of_run;

    int         mismatches;
    int         waiting;
    int         idle_cycles;
    bit         quiet;
    bit         legacy_now = 1'b1;
    bit         cur_pfull;
    bit [255:0] cycle_loaded;

    gain_sequence_frame_packer_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_index       (i_index),
        .i_value       (i_value),
        .i_divider     (i_divider),
        .i_data_mode   (i_data_mode),
        .i_is_duty     (i_is_duty),
        .i_last        (i_last),
        .i_seq_end     (i_seq_end),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_address     (o_address),
        .o_data        (o_data),
        .o_last_of_run (o_last_of_run)
    );

    frame_write_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_index       (i_index),
        .i_value       (i_value),
        .i_divider     (i_divider),
        .i_data_mode   (i_data_mode),
        .i_is_duty     (i_is_duty),
        .i_last        (i_last),
        .i_seq_end     (i_seq_end),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_kind        (o_kind),
        .i_address     (o_address),
        .i_data        (o_data),
        .i_last_of_run (o_last_of_run),
        .o_mismatches  (mismatches),
        .o_waiting     (waiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: ready runs with stall bursts, always ready once quiet
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            i_out_ready <= 1'b1;
            if (quiet) begin
                @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
                if (!quiet) begin
                    i_out_ready <= 1'b0;
                    repeat ($urandom_range(1, 18)) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic drive_item(input logic [1:0] op, input logic [7:0] idx,
                              input logic [15:0] val, input logic [31:0] fdiv,
                              input logic [15:0] dmode, input logic duty,
                              input logic last, input logic seq_end);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_index     <= idx;
        i_value     <= val;
        i_divider   <= fdiv;
        i_data_mode <= dmode;
        i_is_duty   <= duty;
        i_last      <= last;
        i_seq_end   <= seq_end;
        do @(posedge i_clk); while (!o_in_ready);
        if (op == OP_CYCLE && idx < K_NUM_TRANSDUCERS) cycle_loaded[idx] = 1'b1;
        if (op == OP_BEGIN) cur_pfull = (dmode == DMODE_PFULL);
    endtask

    task automatic send_item(input logic [1:0] op, input logic [7:0] idx,
                             input logic [15:0] val, input logic [31:0] fdiv,
                             input logic [15:0] dmode, input logic duty,
                             input logic last, input logic seq_end);
        // load the cycle first when a phase word would read an empty entry
        if (op == OP_GAIN && cur_pfull && !legacy_now && !duty &&
            idx < K_NUM_TRANSDUCERS && !cycle_loaded[idx]) begin
            drive_item(OP_CYCLE, idx, $urandom_range(0, 65535), $urandom,
                       $urandom_range(0, 65535), $urandom_range(0, 1), 1'b0, 1'b0);
        end
        drive_item(op, idx, val, fdiv, dmode, duty, last, seq_end);
    endtask

    // hold until all writes are out, then change the format register
    task automatic set_legacy(input logic v);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (waiting != 0);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        legacy_now = v;
    endtask

    task automatic random_phase(input int n_items);
        int          done;
        int          bodies;
        int          words;
        logic [1:0]  op;
        logic [15:0] dmode;
        logic        duty;
        logic        last;
        done = 0;
        while (done < n_items) begin
            case ($urandom_range(0, 9))
                0: begin
                    op = $urandom_range(0, 3);
                    send_item(op, $urandom_range(0, 255), $urandom_range(0, 65535), $urandom,
                              $urandom_range(0, 65535), $urandom_range(0, 1),
                              $urandom_range(0, 1), $urandom_range(0, 1));
                    if (op != OP_UNKNOWN) done++;
                end
                1: begin
                    send_item(OP_CYCLE, $urandom_range(0, 255), $urandom_range(0, 65535),
                              $urandom, $urandom_range(0, 65535), $urandom_range(0, 1),
                              $urandom_range(0, 1), $urandom_range(0, 1));
                    done++;
                end
                default: begin
                    case ($urandom_range(0, 9))
                        0, 1, 2: dmode = 16'h0001;
                        3, 4, 5: dmode = DMODE_PFULL;
                        6, 7, 8: dmode = DMODE_PHALF;
                        default: dmode = $urandom_range(0, 65535);
                    endcase
                    send_item(OP_BEGIN, $urandom_range(0, 255), $urandom_range(0, 65535),
                              $urandom, dmode, $urandom_range(0, 1),
                              $urandom_range(0, 1), $urandom_range(0, 1));
                    done++;
                    bodies = $urandom_range(1, 12);
                    for (int b = 0; b < bodies; b++) begin
                        duty  = $urandom_range(0, 1);
                        words = $urandom_range(1, 3);
                        for (int w = 0; w < words; w++) begin
                            last = (w == words - 1);
                            // seq_end without last is ignored; sometimes drop it at the end
                            send_item(OP_GAIN,
                                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) :
                                          $urandom_range(0, K_NUM_TRANSDUCERS - 1),
                                      $urandom_range(0, 65535), $urandom,
                                      $urandom_range(0, 65535), duty, last,
                                      last ? (b == bodies - 1 && $urandom_range(0, 7) != 0) :
                                          $urandom_range(0, 1));
                            done++;
                        end
                    end
                end
            endcase
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 1'b0;
        i_in_valid  <= 1'b0;
        i_op        <= OP_BEGIN;
        i_index     <= '0;
        i_value     <= '0;
        i_divider   <= '0;
        i_data_mode <= '0;
        i_is_duty   <= 1'b0;
        i_last      <= 1'b0;
        i_seq_end   <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // legacy format: phase half across a segment boundary
        set_legacy(1'b1);
        send_item(OP_BEGIN, 8'd0, 16'h0000, 32'h0000_0000, DMODE_PHALF, 1'b0, 1'b0, 1'b0);
        send_item(OP_GAIN, 8'd0,   16'h0000, 32'h0, 16'h0, 1'b0, 1'b1, 1'b0);
        send_item(OP_GAIN, 8'd248, 16'hFFFF, 32'h0, 16'h0, 1'b0, 1'b1, 1'b0);
        send_item(OP_GAIN, 8'd7,   16'hFEDC, 32'h0, 16'h0, 1'b1, 1'b1, 1'b0);
        send_item(OP_GAIN, 8'd255, 16'h5A5A, 32'h0, 16'h0, 1'b0, 1'b1, 1'b0);
        send_item(OP_GAIN, 8'd1,   16'h1234, 32'h0, 16'h0, 1'b0, 1'b1, 1'b0);
        send_item(OP_GAIN, 8'd2,   16'h8001, 32'h0, 16'h0, 1'b0, 1'b1, 1'b0);
        send_item(OP_GAIN, 8'd3,   16'h7FFE, 32'h0, 16'h0, 1'b0, 1'b1, 1'b0);
        send_item(OP_GAIN, 8'd4,   16'hA5C3, 32'h0, 16'h0, 1'b0, 1'b1, 1'b1);
        // phase full with an out of range transducer
        send_item(OP_BEGIN, 8'd0, 16'h0000, 32'hFFFF_FFFF, DMODE_PFULL, 1'b0, 1'b0, 1'b0);
        send_item(OP_GAIN, 8'd255, 16'hA5A5, 32'h0, 16'h0, 1'b0, 1'b1, 1'b1);
        // unlisted data mode acts as full
        send_item(OP_BEGIN, 8'd0, 16'h0000, 32'h89AB_CDEF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        send_item(OP_GAIN, 8'd3,   16'hFFFF, 32'h0, 16'h0, 1'b1, 1'b0, 1'b0);
        send_item(OP_GAIN, 8'd248, 16'h0000, 32'h0, 16'h0, 1'b0, 1'b1, 1'b1);
        send_item(OP_UNKNOWN, 8'd9, 16'h1111, 32'h0, 16'h0, 1'b0, 1'b1, 1'b1);
        send_item(OP_CYCLE, 8'd255, 16'h1234, 32'h0, 16'h0, 1'b0, 1'b0, 1'b0);
        send_item(OP_CYCLE, 8'd0,   16'hFFFF, 32'h0, 16'h0, 1'b0, 1'b0, 1'b0);
        send_item(OP_CYCLE, 8'd248, 16'h0000, 32'h0, 16'h0, 1'b0, 1'b0, 1'b0);

        // new format: phase word alone keeps the count, page still checked
        set_legacy(1'b0);
        send_item(OP_BEGIN, 8'd0, 16'h0000, 32'h0000_0001, 16'h0001, 1'b0, 1'b0, 1'b0);
        send_item(OP_GAIN, 8'd1, 16'hBEEF, 32'h0, 16'h0, 1'b0, 1'b1, 1'b0);
        send_item(OP_GAIN, 8'd2, 16'hCAFE, 32'h0, 16'h0, 1'b1, 1'b1, 1'b1);
        send_item(OP_BEGIN, 8'd0, 16'h0000, 32'h0000_0002, DMODE_PFULL, 1'b0, 1'b0, 1'b0);
        send_item(OP_GAIN, 8'd0,   16'h0F0F, 32'h0, 16'h0, 1'b0, 1'b0, 1'b0);
        send_item(OP_GAIN, 8'd248, 16'hF0F0, 32'h0, 16'h0, 1'b0, 1'b1, 1'b0);
        send_item(OP_GAIN, 8'd5,   16'h3333, 32'h0, 16'h0, 1'b1, 1'b1, 1'b1);
        send_item(OP_BEGIN, 8'd0, 16'h0000, 32'h0000_0003, DMODE_PHALF, 1'b0, 1'b0, 1'b0);
        send_item(OP_GAIN, 8'd9, 16'h4444, 32'h0, 16'h0, 1'b0, 1'b1, 1'b1);

        random_phase(30);
        set_legacy(1'b1);
        random_phase(30);
        set_legacy(1'b0);
        random_phase(30);
        set_legacy(1'b1);
        random_phase(30);
        quiet = 1'b1;
        random_phase(15);

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (waiting != 0);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/gsfp_pkg.sv
hdl/gsfp_ram.sv
hdl/gsfp_seq.sv
hdl/gain_sequence_frame_packer_core.sv
test/frame_write_checker.sv
test/gain_sequence_frame_packer_core_tb.sv
